### rtl/bcrt_pkg.sv
// ---------------------------------------------------------------------------
// bcrt_pkg
// Shared constants and types for the barrier clock ratio ticker.
// ---------------------------------------------------------------------------
package bcrt_pkg;

   localparam int MaxClients  = 16;
   localparam int IdWidth     = 4;
   localparam int CountWidth  = 5;
   localparam int PeriodWidth = 16;
   localparam int CycleWidth  = 64;
   localparam int DiffWidth   = 18;
   localparam int CsrIdxWidth = 3;
   localparam int CsrWidth    = 64;
   localparam int ReqDataWidth = 72;
   localparam int RspDataWidth = 136;

   typedef enum logic [CsrIdxWidth-1:0] {
      CsrNumClients = 3'd0,
      CsrFastPeriod = 3'd1,
      CsrSlowPeriod = 3'd2,
      CsrFastStart  = 3'd3,
      CsrSlowStart  = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      StOk         = 4'd0,
      StStale      = 4'd1,
      StDuplicate  = 4'd2,
      StRetry      = 4'd3,
      StBadId      = 4'd4,
      StFuture     = 4'd5,
      StNonePending = 4'd6,
      StNotLeader  = 4'd7,
      StBadConfig  = 4'd8
   } status_type;

   typedef enum logic {
      ReqMark   = 1'b0,
      ReqFinish = 1'b1
   } req_kind_type;

endpackage

### rtl/barrier_clock_ratio_ticker.sv
// ---------------------------------------------------------------------------
// barrier_clock_ratio_ticker
// Multi-controller barrier that advances a fast cycle counter and schedules
// fractional slow-clock ticks through a leader handshake.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one request per item: tuser is the kind (mark or finish),
//   tdata the client id and the fast cycle being marked. rsp_* returns one
//   item per request with status, leader flag and both cycle counters as
//   they stand after that request.
//   csr_* writes a configuration register; any write to a known index also
//   reinitializes the barrier state from the registers. Write only while
//   no request is in flight.
//   Throughput: one item per cycle while the result is taken. A request
//   accepted on req_* sits in an input register and is resolved into the
//   result register, which drives rsp_*; the state update is a flag set,
//   a 64-bit compare and an 18-bit add in that one step.
//   While rsp_tready is low the result holds and one more request is taken
//   into the input register; then req_tready drops until the result moves.
//   Reset loads register defaults (one client, both periods 1 ps, counters
//   at zero), clears all flags and empties both registers.
// ---------------------------------------------------------------------------
module barrier_clock_ratio_ticker (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [3:0] client_id, [67:4] fast_cycle, [71:68] zero
   input  logic [bcrt_pkg::ReqDataWidth-1:0]     req_tdata,
   // [0] req_type
   input  logic                                  req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [3:0] status, [4] is_leader, [68:5] fast_cycle_now,
   // [132:69] slow_cycle_now, [135:133] zero
   output logic [bcrt_pkg::RspDataWidth-1:0]     rsp_tdata,
   // configuration port
   input  logic                                  csr_we,
   input  logic [bcrt_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [bcrt_pkg::CsrWidth-1:0]         csr_wdata
);
   import bcrt_pkg::*;

   // configuration registers
   logic [CountWidth-1:0]  num_clients_ff, num_clients_in;
   logic [PeriodWidth-1:0] fast_period_ff, fast_period_in;
   logic [PeriodWidth-1:0] slow_period_ff, slow_period_in;
   logic [CycleWidth-1:0]  fast_start_ff, fast_start_in;
   logic [CycleWidth-1:0]  slow_start_ff, slow_start_in;
   logic                   reinit;

   // barrier state
   logic [MaxClients-1:0]  flags_ff, flags_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic signed [DiffWidth-1:0] diff_ff, diff_in;
   logic [CycleWidth-1:0]  fast_cnt_ff, fast_cnt_in;
   logic [CycleWidth-1:0]  slow_cnt_ff, slow_cnt_in;
   logic                   pending_ff, pending_in;
   logic [IdWidth-1:0]     leader_ff, leader_in;

   // input register
   logic                   s1_valid_ff, s1_valid_in;
   req_kind_type           s1_kind_ff;
   logic [IdWidth-1:0]     s1_id_ff;
   logic [CycleWidth-1:0]  s1_cycle_ff;

   // result register
   logic                   out_valid_ff, out_valid_in;
   status_type             out_status_ff, status_in;
   logic                   out_leader_ff, lead_in;

   logic advance;
   logic accept;
   logic cfg_ok;
   logic signed [DiffWidth-1:0] diff_add;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // configuration decode; a known index reloads the state from the registers
   always_comb begin
      num_clients_in = num_clients_ff;
      fast_period_in = fast_period_ff;
      slow_period_in = slow_period_ff;
      fast_start_in  = fast_start_ff;
      slow_start_in  = slow_start_ff;
      reinit         = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CsrNumClients: begin
               num_clients_in = csr_wdata[CountWidth-1:0];
               reinit = 1'b1;
            end
            CsrFastPeriod: begin
               fast_period_in = csr_wdata[PeriodWidth-1:0];
               reinit = 1'b1;
            end
            CsrSlowPeriod: begin
               slow_period_in = csr_wdata[PeriodWidth-1:0];
               reinit = 1'b1;
            end
            CsrFastStart: begin
               fast_start_in = csr_wdata;
               reinit = 1'b1;
            end
            CsrSlowStart: begin
               slow_start_in = csr_wdata;
               reinit = 1'b1;
            end
            default: reinit = 1'b0;
         endcase
      end
   end

   assign cfg_ok = (num_clients_ff != '0)
                && (num_clients_ff <= CountWidth'(MaxClients))
                && (fast_period_ff != '0) && (slow_period_ff != '0)
                && (fast_period_ff <= slow_period_ff);

   assign diff_add = diff_ff + $signed({2'b00, fast_period_ff});

   // resolve the request in the input register
   always_comb begin
      flags_in    = flags_ff;
      count_in    = count_ff;
      diff_in     = diff_ff;
      fast_cnt_in = fast_cnt_ff;
      slow_cnt_in = slow_cnt_ff;
      pending_in  = pending_ff;
      leader_in   = leader_ff;
      status_in   = StOk;
      lead_in     = 1'b0;
      if (!cfg_ok) begin
         status_in = StBadConfig;
      end else if (s1_kind_ff == ReqMark) begin
         priority if ({1'b0, s1_id_ff} >= num_clients_ff) begin
            status_in = StBadId;
         end else if (s1_cycle_ff < fast_cnt_ff) begin
            status_in = StStale;
         end else if (s1_cycle_ff > fast_cnt_ff) begin
            status_in = StFuture;
         end else if (pending_ff) begin
            status_in = StRetry;
         end else if (flags_ff[s1_id_ff]) begin
            status_in = StDuplicate;
         end else if (count_ff + 1'b1 == num_clients_ff) begin
            // last mark: complete the barrier and advance fast time
            flags_in    = '0;
            count_in    = '0;
            fast_cnt_in = fast_cnt_ff + 1'b1;
            diff_in     = diff_add;
            if (diff_add > 0) begin
               pending_in = 1'b1;
               leader_in  = s1_id_ff;
               lead_in    = 1'b1;
            end
         end else begin
            flags_in[s1_id_ff] = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end else begin
         priority if (!pending_ff) begin
            status_in = StNonePending;
         end else if (s1_id_ff != leader_ff) begin
            status_in = StNotLeader;
         end else begin
            diff_in     = diff_ff - $signed({2'b00, slow_period_ff});
            slow_cnt_in = slow_cnt_ff + 1'b1;
            pending_in  = 1'b0;
            leader_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_clients_ff <= CountWidth'(1);
         fast_period_ff <= PeriodWidth'(1);
         slow_period_ff <= PeriodWidth'(1);
         fast_start_ff  <= '0;
         slow_start_ff  <= '0;
         flags_ff       <= '0;
         count_ff       <= '0;
         diff_ff        <= '0;
         fast_cnt_ff    <= '0;
         slow_cnt_ff    <= '0;
         pending_ff     <= 1'b0;
         leader_ff      <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         num_clients_ff <= num_clients_in;
         fast_period_ff <= fast_period_in;
         slow_period_ff <= slow_period_in;
         fast_start_ff  <= fast_start_in;
         slow_start_ff  <= slow_start_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
         if (reinit) begin
            flags_ff    <= '0;
            count_ff    <= '0;
            diff_ff     <= '0;
            fast_cnt_ff <= fast_start_in;
            slow_cnt_ff <= slow_start_in;
            pending_ff  <= 1'b0;
            leader_ff   <= '0;
         end else if (advance) begin
            flags_ff    <= flags_in;
            count_ff    <= count_in;
            diff_ff     <= diff_in;
            fast_cnt_ff <= fast_cnt_in;
            slow_cnt_ff <= slow_cnt_in;
            pending_ff  <= pending_in;
            leader_ff   <= leader_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_kind_type'(req_tuser);
         s1_id_ff    <= req_tdata[IdWidth-1:0];
         s1_cycle_ff <= req_tdata[IdWidth +: CycleWidth];
      end
      if (advance) begin
         out_status_ff <= status_in;
         out_leader_ff <= lead_in;
      end
   end

   // counters only change when a result moves in or on a configuration reload, so they match the result
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, slow_cnt_ff, fast_cnt_ff, out_leader_ff, out_status_ff};

endmodule
